[rtl/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// cbs_pkg: shared types and constants of the centered boxcar smoother
// Payload words of both channels, controller commands and datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int STAMP_BITS     = 32;
   localparam int WIDTH_BITS     = 6;
   localparam int MAX_WIDTH      = 32;
   localparam int SUM_BITS       = SAMPLE_BITS + WIDTH_BITS;
   localparam int DIV_COUNT_BITS = $clog2(SUM_BITS);
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   // register index of window_width and its value after reset
   localparam logic                  REG_WINDOW_WIDTH = 1'b0;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET      = 6'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic        [STAMP_BITS-1:0]  stamp;
      logic                          record_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] average;
      logic        [STAMP_BITS-1:0]  center_stamp;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic emit;
      logic div_done;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/cbs_divider.sv]
// ----------------------------------------------------------------------------
// cbs_divider: serial signed divide of the window sum by the window width
// Restoring division on the magnitude, one quotient bit per cycle, sign fixed
// at the end; the quotient truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_divider (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [cbs_pkg::SUM_BITS-1:0]  dividend,
   input  wire logic [cbs_pkg::WIDTH_BITS-1:0]       divisor,
   output logic                                      done,
   output logic signed [cbs_pkg::SAMPLE_BITS-1:0]    quotient
);

   localparam int SB = cbs_pkg::SUM_BITS;
   localparam int WB = cbs_pkg::WIDTH_BITS;
   localparam int CB = cbs_pkg::DIV_COUNT_BITS;
   localparam int QB = cbs_pkg::SAMPLE_BITS;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CB-1:0] count_ff, count_in;
   logic [SB-1:0] mag_ff, mag_in;
   logic [WB-1:0] rem_ff, rem_in;
   logic [WB-1:0] div_ff, div_in;
   logic          neg_ff, neg_in;
   logic [WB:0]   shifted;
   logic [WB:0]   trial;
   logic          qbit;
   logic [QB-1:0] q_low;

   // one restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      shifted = {rem_ff, mag_ff[SB-1]};
      trial   = shifted - {1'b0, div_ff};
      qbit    = (shifted >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = '0;
         neg_in   = dividend[SB-1];
         mag_in   = dividend[SB-1] ? SB'(-dividend) : SB'(dividend);
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = qbit ? trial[WB-1:0] : shifted[WB-1:0];
         mag_in   = {mag_ff[SB-2:0], qbit};
         count_in = count_ff + 1'b1;
         if (count_ff == CB'(SB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   // restore the sign; the magnitude of the quotient fits the sample width
   assign q_low    = mag_ff[QB-1:0];
   assign quotient = neg_ff ? $signed(-q_low) : $signed(q_low);
   assign done     = done_ff;

endmodule

`default_nettype wire

[rtl/cbs_datapath.sv]
// ----------------------------------------------------------------------------
// cbs_datapath: sample and stamp rings, running sum, divider and output word
// Acts on the controller's commands and reports emit, divide and output status.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cbs_pkg::ctl_cmd_type              cmd,
   output cbs_pkg::dp_status_type                 status,
   input  wire cbs_pkg::req_payload_type          req_payload,
   input  wire logic [cbs_pkg::WIDTH_BITS-1:0]    width,
   input  wire logic                              clear,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output cbs_pkg::rsp_payload_type               rsp_payload
);

   localparam int MAX_WIDTH = cbs_pkg::MAX_WIDTH;
   localparam int PB = $clog2(MAX_WIDTH);
   localparam int AW = PB + 1;
   localparam int SB = cbs_pkg::SUM_BITS;
   localparam int WB = cbs_pkg::WIDTH_BITS;

   // ring memories
   logic signed [cbs_pkg::SAMPLE_BITS-1:0] sample_ring [MAX_WIDTH];
   logic [cbs_pkg::STAMP_BITS-1:0]         stamp_ring  [MAX_WIDTH];

   cbs_pkg::req_payload_type               in_ff;
   logic [PB-1:0]                          head_ff, head_in;
   logic [WB-1:0]                          fill_ff, fill_in;
   logic signed [SB-1:0]                   sum_ff, sum_in;
   logic [PB-1:0]                          center_ff;
   logic signed [cbs_pkg::SAMPLE_BITS-1:0] sample_rd_ff;
   logic [cbs_pkg::STAMP_BITS-1:0]         stamp_rd_ff;
   logic                                   rsp_valid_ff;
   cbs_pkg::rsp_payload_type               rsp_ff;

   logic                                   full;
   logic [WB-1:0]                          fill_next;
   logic signed [SB-1:0]                   sum_upd;
   logic [PB-1:0]                          old_addr;
   logic [PB-1:0]                          center_addr;
   logic [PB-1:0]                          head_inc;
   logic                                   emit;
   logic                                   div_done;
   logic signed [cbs_pkg::SAMPLE_BITS-1:0] div_q;

   // step a ring pointer back by a distance of at most the ring depth
   function automatic logic [PB-1:0] ring_back(input logic [PB-1:0] ptr,
                                                input logic [AW-1:0] back);
      logic [AW-1:0] t;
      t = AW'(ptr) + AW'(MAX_WIDTH) - back;
      if (t >= AW'(MAX_WIDTH)) begin
         t = t - AW'(MAX_WIDTH);
      end
      return t[PB-1:0];
   endfunction

   // window arithmetic for the held word
   always_comb begin
      full        = (fill_ff >= width);
      fill_next   = full ? fill_ff : fill_ff + 1'b1;
      sum_upd     = sum_ff + SB'(in_ff.sample)
                    - (full ? SB'(sample_rd_ff) : SB'(0));
      emit        = (fill_next >= width) && !(in_ff.record_end && !width[0]);
      old_addr    = ring_back(head_ff, AW'(width));
      center_addr = ring_back(head_ff, AW'((width - 1'b1) >> 1));
      head_inc    = (32'(head_ff) + 1 == MAX_WIDTH) ? '0 : head_ff + 1'b1;
   end

   // write the new word at the head, read the oldest and the center entries
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         sample_ring[head_ff] <= in_ff.sample;
         stamp_ring[head_ff]  <= in_ff.stamp;
      end
      sample_rd_ff <= sample_ring[old_addr];
      stamp_rd_ff  <= stamp_ring[center_ff];
   end

   // advance or clear the window
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (clear) begin
         head_in = '0;
         fill_in = '0;
         sum_in  = '0;
      end else if (cmd.update) begin
         head_in = in_ff.record_end ? '0 : head_inc;
         fill_in = in_ff.record_end ? '0 : fill_next;
         sum_in  = in_ff.record_end ? '0 : sum_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
      if (cmd.capture) begin
         in_ff <= req_payload;
      end
      if (cmd.update) begin
         center_ff <= center_addr;
      end
   end

   cbs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.update && emit),
      .dividend (sum_upd),
      .divisor  (width),
      .done     (div_done),
      .quotient (div_q)
   );

   // hold the result word until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_ff.average      <= div_q;
         rsp_ff.center_stamp <= stamp_rd_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;
   assign status.emit     = emit;
   assign status.div_done = div_done;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid_ff && rsp_stall))
      else $error("result word overwritten while stalled");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= width)
      else $error("fill count above window width");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < MAX_WIDTH)
      else $error("ring head beyond ring depth");

   a_load_after_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> div_done && !cmd.update)
      else $error("result loaded before divide finished");
`endif

endmodule

`default_nettype wire

[rtl/cbs_controller.sv]
// ----------------------------------------------------------------------------
// cbs_controller: sequencer of the centered boxcar smoother
// Takes one word, updates the window; on emit, divides and loads the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output cbs_pkg::ctl_cmd_type         cmd,
   input  wire cbs_pkg::dp_status_type  status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.update   = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (status.div_done && !status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[rtl/centered_boxcar_smoother_top.sv]
// ----------------------------------------------------------------------------
// centered_boxcar_smoother_top: moving average over a record of samples
//
// Input words (req_) carry a sample, its time stamp and a record-end flag.
// Once window_width samples of a record are held, each word yields one result
// word (rsp_): the window sum divided by the width, truncated toward zero,
// with the stamp of the window's center sample. Record end clears the window;
// with an even width the window ending at the record-end sample is dropped.
// A word that gives a result goes from acceptance to the result register
// through the window update, the bit-serial divide of the 22-bit sum and
// the load of the result. The next word is taken only once the result is
// loaded, or once the window is updated for a word with no result.
// One word is in flight at a time; req_stall is high meanwhile.
// The result register holds while rsp_stall is high; the next word is still
// taken and waits at its final divide step until the register is free.
// Reset clears the window and sets the width to 3; ring contents are left.
// A write to window_width (address 0, low six bits, 0 taken as 1, saturated at
// MAX_WIDTH) also clears the window; write it only while the block idles.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_boxcar_smoother_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire cbs_pkg::req_payload_type              req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output cbs_pkg::rsp_payload_type                   rsp_payload,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [cbs_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [cbs_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [cbs_pkg::CSR_DATA_BITS-1:0]          csr_prdata,
   output logic                                       csr_pready
);

   localparam int WB = cbs_pkg::WIDTH_BITS;

   logic [WB-1:0]          width_ff, width_in;
   logic                   width_wr;
   logic [WB-1:0]          wdata;
   cbs_pkg::ctl_cmd_type   cmd;
   cbs_pkg::dp_status_type status;

   // register write: zero taken as one, saturate at the ring depth
   always_comb begin
      width_wr = csr_psel && csr_penable && csr_pwrite
                 && (csr_paddr[2] == cbs_pkg::REG_WINDOW_WIDTH);
      wdata    = csr_pwdata[WB-1:0];
      width_in = width_ff;
      if (width_wr) begin
         if (wdata == '0) begin
            width_in = WB'(1);
         end else if (32'(wdata) > cbs_pkg::MAX_WIDTH) begin
            width_in = WB'(cbs_pkg::MAX_WIDTH);
         end else begin
            width_in = wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= cbs_pkg::WIDTH_RESET;
      end else begin
         width_ff <= width_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == cbs_pkg::REG_WINDOW_WIDTH)
                       ? cbs_pkg::CSR_DATA_BITS'(width_ff) : '0;

   cbs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   cbs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .width       (width_ff),
      .clear       (width_wr),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for centered_boxcar_smoother_top
// Sends records of stamped samples through several window widths and idle
// patterns. A tracker mirrors the window and checks each average word in order.
// ----------------------------------------------------------------------------

module testbench;

   localparam int RING_DEPTH    = 32;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 800_000;
   localparam int PHASE_WORDS   = 120;
   localparam int LONG_HOLD     = 400;

   localparam logic [cbs_pkg::CSR_ADDR_BITS-1:0] WIDTH_ADDR =
      {cbs_pkg::REG_WINDOW_WIDTH, 2'b00};
   localparam logic [cbs_pkg::CSR_ADDR_BITS-1:0] SPARE_ADDR = 3'd4;

   // Mirror of the window: ring, running sum and the averages still due
   class moving_average_tracker;
      logic signed [cbs_pkg::SAMPLE_BITS-1:0] sample_ring [RING_DEPTH];
      logic [cbs_pkg::STAMP_BITS-1:0]         stamp_ring [RING_DEPTH];
      int                                     head;
      int                                     fill;
      int                                     sum;
      int                                     span;
      int                                     errors;
      cbs_pkg::rsp_payload_type               expected_averages [$];

      function new();
         span   = int'(cbs_pkg::WIDTH_RESET);
         errors = 0;
         clear_window();
      endfunction

      function void clear_window();
         head = 0;
         fill = 0;
         sum  = 0;
      endfunction

      // Apply a width write: keep six bits, lift zero, saturate at the ring depth
      function void set_width(input logic [cbs_pkg::CSR_DATA_BITS-1:0] value);
         int w;
         w = int'(value[cbs_pkg::WIDTH_BITS-1:0]);
         if (w == 0) w = 1;
         if (w > RING_DEPTH) w = RING_DEPTH;
         span = w;
         clear_window();
      endfunction

      // Advance the window by one accepted word and queue its average, if any
      function void take_sample(input cbs_pkg::req_payload_type word);
         cbs_pkg::rsp_payload_type due;
         int                       slot;
         slot = head;
         if (fill >= span) begin
            sum -= sample_ring[(slot + RING_DEPTH - span) % RING_DEPTH];
         end else begin
            fill++;
         end
         sample_ring[slot] = word.sample;
         stamp_ring[slot]  = word.stamp;
         sum += word.sample;
         head = (slot + 1) % RING_DEPTH;
         // even width drops the window that closes the record
         if (fill >= span && !(word.record_end && (span % 2 == 0))) begin
            due.average      = cbs_pkg::SAMPLE_BITS'(sum / span);
            due.center_stamp =
               stamp_ring[(slot + RING_DEPTH - span + 1 + span / 2) % RING_DEPTH];
            expected_averages = {expected_averages, due};
         end
         if (word.record_end) clear_window();
      endfunction

      function void check_average(input cbs_pkg::rsp_payload_type got);
         cbs_pkg::rsp_payload_type due;
         if (expected_averages.size() == 0) begin
            $error("unexpected result word: average %0d, center_stamp %0h",
                   got.average, got.center_stamp);
            errors++;
            return;
         end
         due = expected_averages.pop_front();
         if (got.average !== due.average) begin
            $error("average: expected %0d, actual %0d", due.average, got.average);
            errors++;
         end
         if (got.center_stamp !== due.center_stamp) begin
            $error("center_stamp: expected %0h, actual %0h",
                   due.center_stamp, got.center_stamp);
            errors++;
         end
      endfunction

      function int pending();
         return expected_averages.size();
      endfunction
   endclass

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   cbs_pkg::req_payload_type          req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   cbs_pkg::rsp_payload_type          rsp_payload;
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [cbs_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [cbs_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [cbs_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   int                     send_idle_pct = 0;
   int                     stall_pct     = 0;
   int                     hold_cycles   = 0;
   int                     cycle_count   = 0;
   moving_average_tracker  tracker       = new();

   centered_boxcar_smoother_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Note every accepted input word, check every accepted result word
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) tracker.take_sample(req_payload);
      if (!reset && rsp_valid && !rsp_stall) tracker.check_average(rsp_payload);
   end

   // Receiver: random stall, or a long hold when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one word, idling first at random; return at the accepting edge
   task automatic send_word(input logic signed [cbs_pkg::SAMPLE_BITS-1:0] value,
                            input logic [cbs_pkg::STAMP_BITS-1:0] stamp,
                            input logic last);
      cbs_pkg::req_payload_type word;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      word.sample     = value;
      word.stamp      = stamp;
      word.record_end = last;
      req_valid   <= 1'b1;
      req_payload <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait out every due average and the block's own latency
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready, then idle
   task automatic csr_write(input logic [cbs_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [cbs_pkg::CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == WIDTH_ADDR) tracker.set_width(data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Random records: mostly full windows, some short, a few merged into the next
   task automatic run_records(input int budget);
      int                                     left;
      int                                     len;
      int                                     pick;
      logic signed [cbs_pkg::SAMPLE_BITS-1:0] value;
      logic                                   closes;
      left = budget;
      while (left > 0) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            len = $urandom_range(1, (tracker.span > 1) ? tracker.span - 1 : 1);
         end else begin
            len = $urandom_range(tracker.span, 3 * tracker.span + 8);
         end
         if (len > left) len = left;
         closes = ($urandom_range(99) >= 5);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 3)       value = 16'sh7FFF;
            else if (pick < 6)  value = 16'sh8000;
            else if (pick < 8)  value = 16'sh0000;
            else if (pick < 10) value = -16'sd1;
            else                value = cbs_pkg::SAMPLE_BITS'($urandom);
            send_word(value, $urandom, closes && (i == len - 1));
         end
         left -= len;
      end
   endtask

   logic [cbs_pkg::CSR_DATA_BITS-1:0] phase_width [12];

   initial begin
      phase_width = '{32'd1, 32'd2, 32'd32, 32'd0, 32'd63, 32'd33, 32'hFFFF_FFC6,
                      32'd4, 32'd17, 32'd16, 32'd7, 32'd0};
      phase_width[11] = $urandom_range(1, 32);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Width 3 from reset: extremes, truncation toward zero, short records
      send_word(16'sh7FFF, 32'hFFFF_FFFF, 1'b0);
      send_word(16'sh7FFF, 32'h0000_0000, 1'b0);
      send_word(16'sh7FFF, 32'h0000_0001, 1'b1);
      send_word(16'sh8000, 32'h5555_5555, 1'b0);
      send_word(16'sh8000, 32'hAAAA_AAAA, 1'b0);
      send_word(16'sh8000, 32'h0000_0002, 1'b1);
      send_word(-16'sd1, 32'd10, 1'b0);
      send_word(16'sd0, 32'd11, 1'b0);
      send_word(16'sd0, 32'd12, 1'b0);
      send_word(-16'sd2, 32'd13, 1'b0);
      send_word(16'sd1, 32'd14, 1'b1);
      send_word(16'sd5, 32'd20, 1'b0);
      send_word(16'sd6, 32'd21, 1'b1);
      send_word(16'sd7, 32'd22, 1'b1);
      settle();

      // Even width: the window that closes the record is dropped
      csr_write(WIDTH_ADDR, 32'd4);
      send_word(16'sd100, 32'd30, 1'b0);
      send_word(16'sd200, 32'd31, 1'b0);
      send_word(16'sd300, 32'd32, 1'b0);
      send_word(16'sd400, 32'd33, 1'b0);
      send_word(-16'sd500, 32'd34, 1'b1);
      settle();

      // Width change in the middle of a record starts a new window
      csr_write(WIDTH_ADDR, 32'd5);
      send_word(16'sd1, 32'd40, 1'b0);
      send_word(16'sd2, 32'd41, 1'b0);
      settle();
      csr_write(WIDTH_ADDR, 32'd2);
      send_word(16'sd3, 32'd42, 1'b0);
      send_word(16'sd4, 32'd43, 1'b0);
      send_word(16'sd5, 32'd44, 1'b1);
      settle();

      // Random phases over widths and idle patterns
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         csr_write(WIDTH_ADDR, phase_width[phase]);
         if (phase == 6) csr_write(SPARE_ADDR, 32'd9);
         // hold the receiver off while words keep coming, to back up the input
         if (phase == 4) hold_cycles = LONG_HOLD;
         run_records(PHASE_WORDS);
         settle();
      end

      if (tracker.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
